[rtl/overheat_guard_fan_controller_assert.svh]
// Assertion macros shared by the fan controller RTL.
`ifndef OVERHEAT_GUARD_FAN_CONTROLLER_ASSERT_SVH
`define OVERHEAT_GUARD_FAN_CONTROLLER_ASSERT_SVH
`ifndef SYNTH
// Plain clocked property, disabled during reset.
`define OGFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Antecedent in this cycle, consequent in the next one.
`define OGFC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);
`else
`define OGFC_ASSERT(lbl, prop, msg)
`define OGFC_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

[rtl/ogfc_pkg.sv]
// Types, constants and the fan curve for the overheat guard fan controller.
package ogfc_pkg;

  localparam int TEMP_W = 12;
  localparam int TS_W   = 32;
  localparam int DUTY_W = 8;
  localparam int SECS_W = 13;
  localparam int MODE_W = 2;

  // Mode codes as seen on the result port
  localparam logic [MODE_W-1:0] MODE_ADJUSTING    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RUNNING      = 2'd1;
  localparam logic [MODE_W-1:0] MODE_OVERHEAT     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RESTART_WAIT = 2'd3;

  typedef enum logic [3:0] {
    ST_ADJUSTING = 4'b0001,
    ST_RUNNING   = 4'b0010,
    ST_OVERHEAT  = 4'b0100,
    ST_RESTART   = 4'b1000
  } mode_state_e;

  typedef enum logic [1:0] {
    CFG_WARNING  = 2'd0,
    CFG_OVERHEAT = 2'd1,
    CFG_RESTART  = 2'd2
  } cfg_idx_e;

  localparam logic signed [TEMP_W-1:0] WARNING_RST  = 12'sd500;
  localparam logic signed [TEMP_W-1:0] OVERHEAT_RST = 12'sd600;
  localparam logic signed [TEMP_W-1:0] RESTART_RST  = 12'sd450;

  // Curve break points, tenths of a degree
  localparam logic signed [TEMP_W-1:0] CURVE_T1 = 12'sd350;
  localparam logic signed [TEMP_W-1:0] CURVE_T2 = 12'sd400;
  localparam logic signed [TEMP_W-1:0] CURVE_T3 = 12'sd450;
  localparam logic signed [TEMP_W-1:0] CURVE_T4 = 12'sd500;
  localparam logic signed [TEMP_W-1:0] CURVE_T5 = 12'sd550;
  localparam logic signed [TEMP_W-1:0] CURVE_T6 = 12'sd600;

  localparam logic [DUTY_W-1:0] DUTY_0   = 8'd0;
  localparam logic [DUTY_W-1:0] DUTY_1   = 8'd70;
  localparam logic [DUTY_W-1:0] DUTY_2   = 8'd100;
  localparam logic [DUTY_W-1:0] DUTY_3   = 8'd140;
  localparam logic [DUTY_W-1:0] DUTY_4   = 8'd180;
  localparam logic [DUTY_W-1:0] DUTY_5   = 8'd220;
  localparam logic [DUTY_W-1:0] DUTY_MAX = 8'd255;

  // Divide by 1e6: drop 2^6, then x/15625 = (x * ceil(2^40/15625)) >> 40,
  // exact for a 26-bit x.
  localparam int US_SHIFT  = 6;
  localparam int US_W      = TS_W - US_SHIFT;
  localparam int SEC_RCP_W = 27;
  localparam logic [SEC_RCP_W-1:0] SEC_RCP = 27'd70368745;
  localparam int SEC_SHIFT = 40;

  // Divide by 250: drop 2^1, then x/125 = (x * ceil(2^38/125)) >> 38,
  // exact for a 31-bit x. Only the quotient LSB is kept.
  localparam int MS_SHIFT    = 1;
  localparam int MS_W        = TS_W - MS_SHIFT;
  localparam int BLINK_RCP_W = 32;
  localparam logic [BLINK_RCP_W-1:0] BLINK_RCP = 32'd2199023256;
  localparam int BLINK_SHIFT = 38;

  typedef struct packed {
    logic signed [TEMP_W-1:0] warning_temp;
    logic signed [TEMP_W-1:0] overheat_temp;
    logic signed [TEMP_W-1:0] restart_temp;
  } cfg_t;

  // One tick after the mode step, before the time dividers
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [DUTY_W-1:0] duty;
    logic              overheat;
    logic              alarm;
    logic [US_W-1:0]   us_scaled;
    logic [MS_W-1:0]   ms_half;
  } tick_t;

  function automatic logic [DUTY_W-1:0] curve_duty(input logic signed [TEMP_W-1:0] t);
    logic [DUTY_W-1:0] d;
    if (t < CURVE_T1) d = DUTY_0;
    else if (t < CURVE_T2) d = DUTY_1;
    else if (t < CURVE_T3) d = DUTY_2;
    else if (t < CURVE_T4) d = DUTY_3;
    else if (t < CURVE_T5) d = DUTY_4;
    else if (t < CURVE_T6) d = DUTY_5;
    else d = DUTY_MAX;
    return d;
  endfunction

  function automatic logic [MODE_W-1:0] mode_code(input mode_state_e s);
    logic [MODE_W-1:0] c;
    unique case (s)
      ST_ADJUSTING: c = MODE_ADJUSTING;
      ST_RUNNING:   c = MODE_RUNNING;
      ST_OVERHEAT:  c = MODE_OVERHEAT;
      ST_RESTART:   c = MODE_RESTART_WAIT;
      default:      c = MODE_ADJUSTING;
    endcase
    return c;
  endfunction

endpackage

[rtl/overheat_guard_fan_controller.sv]
// Overheat guard fan controller top level: ports, config registers, pipeline.
//
// Channel  Dir  Handshake                 Payload
// in       in   in_valid_i / in_ready_o   temp_tenths_i, run_switch_i, now_us_i, now_ms_i
// out      out  out_valid_o / out_ready_i mode_o, fan_duty_o, relay_on_o, alarm_on_o,
//                                         alarm_led_o, elapsed_seconds_o
// cfg      in   cfg_valid_i / cfg_ready_o cfg_idx_i, cfg_data_i
//
// One beat per cycle sustained while out_ready_i is high; a beat passes the input
// register, the mode step register and the result register on its way out.
// The mode step sets the pace: mode and stopwatch start update together.
// Reset puts the mode in adjusting, clears the stopwatch and loads the
// default thresholds. A stalled result stays in place; beats behind it fill only empty stages;
// cfg is always ready and should only be written while the pipe is empty.
`include "overheat_guard_fan_controller_assert.svh"
module overheat_guard_fan_controller (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input items
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [ogfc_pkg::TEMP_W-1:0]   temp_tenths_i,
  input  logic                                 run_switch_i,
  input  logic        [ogfc_pkg::TS_W-1:0]     now_us_i,
  input  logic        [ogfc_pkg::TS_W-1:0]     now_ms_i,
  // results
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic        [ogfc_pkg::MODE_W-1:0]   mode_o,
  output logic        [ogfc_pkg::DUTY_W-1:0]   fan_duty_o,
  output logic                                 relay_on_o,
  output logic                                 alarm_on_o,
  output logic                                 alarm_led_o,
  output logic        [ogfc_pkg::SECS_W-1:0]   elapsed_seconds_o,
  // config writes
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic        [1:0]                    cfg_idx_i,
  input  logic signed [ogfc_pkg::TEMP_W-1:0]   cfg_data_i
);

  // config registers
  ogfc_pkg::cfg_t cfg_q;

  // stage 1: input register
  logic                                in_vld_q;
  logic signed [ogfc_pkg::TEMP_W-1:0]  temp_q;
  logic                                run_q;
  logic        [ogfc_pkg::TS_W-1:0]    now_us_q;
  logic        [ogfc_pkg::TS_W-1:0]    now_ms_q;

  // stage 2: after the mode step
  logic                                mid_vld_q;
  ogfc_pkg::tick_t                     mid_q;
  ogfc_pkg::tick_t                     tick;

  // stage 3: result register
  logic                                out_vld_q;
  logic        [ogfc_pkg::MODE_W-1:0]  mode_q;
  logic        [ogfc_pkg::DUTY_W-1:0]  duty_q;
  logic                                relay_q;
  logic                                alarm_q;
  logic                                led_q;
  logic        [ogfc_pkg::SECS_W-1:0]  secs_q;

  logic                                out_adv;
  logic                                mid_adv;
  logic                                step;
  logic        [ogfc_pkg::SECS_W-1:0]  secs;
  logic                                blink;

  // backpressure: each stage moves when the one after it can take the beat
  assign out_adv    = !out_vld_q || out_ready_i;
  assign mid_adv    = !mid_vld_q || out_adv;
  assign in_ready_o = !in_vld_q || mid_adv;
  assign step       = in_vld_q && mid_adv;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.warning_temp  <= ogfc_pkg::WARNING_RST;
      cfg_q.overheat_temp <= ogfc_pkg::OVERHEAT_RST;
      cfg_q.restart_temp  <= ogfc_pkg::RESTART_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_i)
        ogfc_pkg::CFG_WARNING:  cfg_q.warning_temp  <= cfg_data_i;
        ogfc_pkg::CFG_OVERHEAT: cfg_q.overheat_temp <= cfg_data_i;
        ogfc_pkg::CFG_RESTART:  cfg_q.restart_temp  <= cfg_data_i;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      mid_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) in_vld_q  <= in_valid_i;
      if (mid_adv)    mid_vld_q <= in_vld_q;
      if (out_adv)    out_vld_q <= mid_vld_q;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      temp_q   <= temp_tenths_i;
      run_q    <= run_switch_i;
      now_us_q <= now_us_i;
      now_ms_q <= now_ms_i;
    end
    if (step) begin
      mid_q <= tick;
    end
    if (mid_vld_q && out_adv) begin
      mode_q  <= mid_q.mode;
      duty_q  <= mid_q.duty;
      relay_q <= !mid_q.overheat;
      alarm_q <= mid_q.alarm;
      led_q   <= mid_q.alarm && blink;
      secs_q  <= secs;
    end
  end

  ogfc_mode_fsm u_mode_fsm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .temp_i   (temp_q),
    .run_i    (run_q),
    .now_us_i (now_us_q),
    .now_ms_i (now_ms_q),
    .cfg_i    (cfg_q),
    .tick_o   (tick)
  );

  ogfc_timebase u_timebase (
    .tick_i  (mid_q),
    .secs_o  (secs),
    .blink_o (blink)
  );

  assign out_valid_o       = out_vld_q;
  assign mode_o            = mode_q;
  assign fan_duty_o        = duty_q;
  assign relay_on_o        = relay_q;
  assign alarm_on_o        = alarm_q;
  assign alarm_led_o       = led_q;
  assign elapsed_seconds_o = secs_q;

  `OGFC_ASSERT(a_overheat_outputs, !(out_valid_o && (mode_o == ogfc_pkg::MODE_OVERHEAT)) || ((fan_duty_o == ogfc_pkg::DUTY_MAX) && !relay_on_o && alarm_on_o), "overheat result without full fan and relay off")
  `OGFC_ASSERT(a_secs_only_running, !(out_valid_o && (mode_o != ogfc_pkg::MODE_RUNNING)) || (elapsed_seconds_o == '0), "elapsed seconds nonzero outside running")
  `OGFC_ASSERT(a_relay_vs_mode, !out_valid_o || (relay_on_o == (mode_o != ogfc_pkg::MODE_OVERHEAT)), "relay enable disagrees with mode")
  `OGFC_ASSERT(a_led_needs_alarm, !(out_valid_o && alarm_led_o) || alarm_on_o, "alarm LED lit without alarm")

endmodule

[rtl/ogfc_mode_fsm.sv]
// Mode state machine, stopwatch start and per-tick temperature decisions.
`include "overheat_guard_fan_controller_assert.svh"
module ogfc_mode_fsm (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 step_i,
  input  logic signed [ogfc_pkg::TEMP_W-1:0]   temp_i,
  input  logic                                 run_i,
  input  logic        [ogfc_pkg::TS_W-1:0]     now_us_i,
  input  logic        [ogfc_pkg::TS_W-1:0]     now_ms_i,
  input  ogfc_pkg::cfg_t                       cfg_i,
  output ogfc_pkg::tick_t                      tick_o
);

  ogfc_pkg::mode_state_e           state_q, state_d;
  logic [ogfc_pkg::TS_W-1:0]       start_us_q, start_us_d;
  logic [ogfc_pkg::TS_W-1:0]       diff;
  logic                            overheat;

  always_comb begin
    state_d    = state_q;
    start_us_d = start_us_q;
    unique case (state_q)
      ogfc_pkg::ST_ADJUSTING: begin
        if (run_i && (temp_i < $signed(cfg_i.overheat_temp))) begin
          state_d    = ogfc_pkg::ST_RUNNING;
          start_us_d = now_us_i;
        end
      end
      ogfc_pkg::ST_RUNNING: begin
        if (!run_i) begin
          state_d = ogfc_pkg::ST_ADJUSTING;
        end else if (temp_i >= $signed(cfg_i.overheat_temp)) begin
          state_d = ogfc_pkg::ST_OVERHEAT;
        end
      end
      ogfc_pkg::ST_OVERHEAT: begin
        if (temp_i <= $signed(cfg_i.restart_temp)) begin
          state_d = ogfc_pkg::ST_RESTART;
        end
      end
      ogfc_pkg::ST_RESTART: begin
        if (!run_i) begin
          state_d = ogfc_pkg::ST_ADJUSTING;
        end
      end
      default: state_d = ogfc_pkg::ST_ADJUSTING;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ogfc_pkg::ST_ADJUSTING;
      start_us_q <= '0;
    end else if (step_i) begin
      state_q    <= state_d;
      start_us_q <= start_us_d;
    end
  end

  // stopwatch runs exactly while in running; zero on the start tick
  assign diff     = now_us_i - start_us_d;
  assign overheat = (state_d == ogfc_pkg::ST_OVERHEAT);

  always_comb begin
    tick_o.mode      = ogfc_pkg::mode_code(state_d);
    tick_o.overheat  = overheat;
    tick_o.alarm     = (temp_i >= $signed(cfg_i.warning_temp)) || overheat;
    tick_o.duty      = overheat ? ogfc_pkg::DUTY_MAX : ogfc_pkg::curve_duty(temp_i);
    tick_o.us_scaled = (state_d == ogfc_pkg::ST_RUNNING) ?
                       diff[ogfc_pkg::TS_W-1:ogfc_pkg::US_SHIFT] : '0;
    tick_o.ms_half   = now_ms_i[ogfc_pkg::TS_W-1:ogfc_pkg::MS_SHIFT];
  end

  // overheat only ever leaves toward restart wait
  `OGFC_ASSERT_NEXT(a_overheat_exit, step_i && (state_q == ogfc_pkg::ST_OVERHEAT), (state_q == ogfc_pkg::ST_OVERHEAT) || (state_q == ogfc_pkg::ST_RESTART), "overheat left to a mode other than restart wait")

endmodule

[rtl/ogfc_timebase.sv]
// Constant dividers: elapsed whole seconds and the 250 ms blink phase.
module ogfc_timebase (
  input  ogfc_pkg::tick_t                  tick_i,
  output logic [ogfc_pkg::SECS_W-1:0]      secs_o,
  output logic                             blink_o
);

  localparam int SEC_PROD_W   = ogfc_pkg::US_W + ogfc_pkg::SEC_RCP_W;
  localparam int BLINK_PROD_W = ogfc_pkg::MS_W + ogfc_pkg::BLINK_RCP_W;

  logic [SEC_PROD_W-1:0]   sec_prod;
  logic [BLINK_PROD_W-1:0] blink_prod;

  assign sec_prod   = SEC_PROD_W'(tick_i.us_scaled) * SEC_PROD_W'(ogfc_pkg::SEC_RCP);
  assign blink_prod = BLINK_PROD_W'(tick_i.ms_half) * BLINK_PROD_W'(ogfc_pkg::BLINK_RCP);

  assign secs_o  = sec_prod[ogfc_pkg::SEC_SHIFT +: ogfc_pkg::SECS_W];
  assign blink_o = blink_prod[ogfc_pkg::BLINK_SHIFT];

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the overheat guard fan controller: directed and random ticks.
module tb_top;

  localparam int HALF_PERIOD    = 1;
  localparam int RESET_CYCLES   = 5;
  localparam int TIMEOUT_CYCLES = 400000;
  // Pipe is three deep; wait out a drain period so a stray beat can show.
  localparam int DRAIN_CYCLES   = 10;
  localparam int HOLD_CYCLES    = 200;
  localparam int MAX_REPORTS    = 10;

  localparam int TEMP_W = ogfc_pkg::TEMP_W;
  localparam int TS_W   = ogfc_pkg::TS_W;
  localparam int MODE_W = ogfc_pkg::MODE_W;
  localparam int DUTY_W = ogfc_pkg::DUTY_W;
  localparam int SECS_W = ogfc_pkg::SECS_W;

  // Index 3 decodes to no register; writes there must change nothing.
  localparam logic [1:0] CFG_SPARE = 2'd3;

  // Fan curve: six thresholds, 5.0 C apart, starting at 35.0 C.
  localparam int CURVE_BASE  = 350;
  localparam int CURVE_STEP  = 50;
  localparam int CURVE_EDGES = 6;

  localparam logic [TS_W-1:0] US_PER_SEC = 32'd1000000;
  localparam logic [TS_W-1:0] BLINK_MS   = 32'd250;

  // One result beat, as the block should present it.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [DUTY_W-1:0] duty;
    logic              relay;
    logic              alarm;
    logic              led;
    logic [SECS_W-1:0] secs;
  } status_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                     in_valid_i    = 1'b0;
  logic                     in_ready_o;
  logic signed [TEMP_W-1:0] temp_tenths_i = '0;
  logic                     run_switch_i  = 1'b0;
  logic [TS_W-1:0]          now_us_i      = '0;
  logic [TS_W-1:0]          now_ms_i      = '0;

  logic                     out_valid_o;
  logic                     out_ready_i   = 1'b0;
  logic [MODE_W-1:0]        mode_o;
  logic [DUTY_W-1:0]        fan_duty_o;
  logic                     relay_on_o;
  logic                     alarm_on_o;
  logic                     alarm_led_o;
  logic [SECS_W-1:0]        elapsed_seconds_o;

  logic                     cfg_valid_i   = 1'b0;
  logic                     cfg_ready_o;
  logic [1:0]               cfg_idx_i     = '0;
  logic signed [TEMP_W-1:0] cfg_data_i    = '0;

  // Shadow of the thresholds and of the mode machine, advanced once per
  // accepted input beat.
  logic signed [TEMP_W-1:0] warn_lvl    = ogfc_pkg::WARNING_RST;
  logic signed [TEMP_W-1:0] trip_lvl    = ogfc_pkg::OVERHEAT_RST;
  logic signed [TEMP_W-1:0] restart_lvl = ogfc_pkg::RESTART_RST;
  logic [MODE_W-1:0]        pm_mode     = ogfc_pkg::MODE_ADJUSTING;
  logic [TS_W-1:0]          pm_start_us = '0;
  logic                     pm_watch_on = 1'b0;

  status_t pending_status[$];
  int      errors = 0;

  // Traffic shaping: percent of cycles the sender idles / receiver stalls.
  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  // Receiver hold-off: raised at a rising edge, picked up at the falling one.
  bit hold_req  = 1'b0;
  int hold_left = 0;

  // Plausible timestamps for well-formed tick streams.
  logic [TS_W-1:0] us_clock;
  logic [TS_W-1:0] ms_clock;

  overheat_guard_fan_controller DUT (.*);

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // Duty from the number of curve edges at or below the sample.
  function automatic logic [DUTY_W-1:0] fan_curve(input logic signed [TEMP_W-1:0] t);
    int               steps;
    logic [DUTY_W-1:0] d;
    steps = 0;
    for (int k = 0; k < CURVE_EDGES; k++)
      if (int'(t) >= CURVE_BASE + k * CURVE_STEP) steps++;
    case (steps)
      0:       d = ogfc_pkg::DUTY_0;
      1:       d = ogfc_pkg::DUTY_1;
      2:       d = ogfc_pkg::DUTY_2;
      3:       d = ogfc_pkg::DUTY_3;
      4:       d = ogfc_pkg::DUTY_4;
      5:       d = ogfc_pkg::DUTY_5;
      default: d = ogfc_pkg::DUTY_MAX;
    endcase
    return d;
  endfunction

  // Step the shadow mode machine with one tick, then form its outputs from
  // the new mode and the same sample.
  function automatic status_t predict_status(input logic signed [TEMP_W-1:0] t,
                                             input logic run,
                                             input logic [TS_W-1:0] us,
                                             input logic [TS_W-1:0] ms);
    status_t         s;
    logic [TS_W-1:0] span;
    logic [TS_W-1:0] blink;
    case (pm_mode)
      ogfc_pkg::MODE_ADJUSTING: begin
        pm_watch_on = 1'b0;
        // Start only below the trip level; stopwatch starts on this tick.
        if (run && t < trip_lvl) begin
          pm_mode     = ogfc_pkg::MODE_RUNNING;
          pm_start_us = us;
          pm_watch_on = 1'b1;
        end
      end
      ogfc_pkg::MODE_RUNNING: begin
        // Switch-off wins over an overheat on the same tick.
        if (!run) begin
          pm_mode     = ogfc_pkg::MODE_ADJUSTING;
          pm_watch_on = 1'b0;
        end else if (t >= trip_lvl) begin
          pm_mode     = ogfc_pkg::MODE_OVERHEAT;
          pm_watch_on = 1'b0;
        end
      end
      ogfc_pkg::MODE_OVERHEAT: begin
        if (t <= restart_lvl) pm_mode = ogfc_pkg::MODE_RESTART_WAIT;
      end
      default: begin
        if (!run) pm_mode = ogfc_pkg::MODE_ADJUSTING;
      end
    endcase
    span    = us - pm_start_us;   // wraps mod 2^32
    blink   = ms / BLINK_MS;
    s.mode  = pm_mode;
    s.relay = (pm_mode != ogfc_pkg::MODE_OVERHEAT);
    s.alarm = (t >= warn_lvl) || !s.relay;
    s.duty  = s.relay ? fan_curve(t) : ogfc_pkg::DUTY_MAX;
    s.led   = s.alarm & blink[0];
    s.secs  = pm_watch_on ? SECS_W'(span / US_PER_SEC) : '0;
    return s;
  endfunction

  // Offer one tick; predict its result once the beat is taken.
  task automatic send_tick(input logic signed [TEMP_W-1:0] t, input logic run,
                           input logic [TS_W-1:0] us, input logic [TS_W-1:0] ms);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    temp_tenths_i <= t;
    run_switch_i  <= run;
    now_us_i      <= us;
    now_ms_i      <= ms;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_status.push_back(predict_status(t, run, us, ms));
  endtask

  // Drop valid and wait for the pipe to hand back everything in flight.
  task automatic end_phase();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic signed [TEMP_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      ogfc_pkg::CFG_WARNING:  warn_lvl    = data;
      ogfc_pkg::CFG_OVERHEAT: trip_lvl    = data;
      ogfc_pkg::CFG_RESTART:  restart_lvl = data;
      default: ;
    endcase
  endtask

  // All three thresholds plus a junk write to the unused index.
  task automatic write_thresholds(input logic signed [TEMP_W-1:0] w,
                                  input logic signed [TEMP_W-1:0] o,
                                  input logic signed [TEMP_W-1:0] r);
    write_reg(ogfc_pkg::CFG_WARNING, w);
    write_reg(ogfc_pkg::CFG_OVERHEAT, o);
    write_reg(ogfc_pkg::CFG_RESTART, r);
    write_reg(CFG_SPARE, TEMP_W'($urandom));
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Every curve edge, one tenth below the first, blink phase alternating.
  task automatic test_fan_curve();
    send_tick(TEMP_W'(CURVE_BASE - 1), 1'b0, 32'd0, 32'd0);
    for (int k = 0; k < CURVE_EDGES; k++)
      send_tick(TEMP_W'(CURVE_BASE + k * CURVE_STEP), 1'b0, TS_W'(k), TS_W'(k * 250));
  endtask

  // Most negative / most positive sample, all-ones and checkerboard stamps.
  task automatic test_field_extremes();
    send_tick(12'sh800, 1'b0, 32'h0000_0000, 32'h0000_0000);
    send_tick(12'sh7FF, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_tick(12'sd0, 1'b0, 32'h5555_5555, 32'hAAAA_AAAA);
  endtask

  // Walk every mode transition with the reset thresholds.
  task automatic test_mode_walk();
    logic [TS_W-1:0] t0;
    t0 = 32'hFFFF_FF00;
    send_tick(12'sd599, 1'b1, t0, 32'd0);                 // start: zero seconds same tick
    send_tick(12'sd0, 1'b1, t0 + 32'd5000123, 32'd250);   // stamp wraps, 5 s
    send_tick(12'sd100, 1'b1, t0 - 32'd1, 32'd750);       // largest span, 4294 s
    send_tick(12'sd600, 1'b1, 32'd7, 32'd250);            // trip
    send_tick(12'sd451, 1'b1, 32'd8, 32'd499);            // still hot
    send_tick(12'sd450, 1'b1, 32'd9, 32'd500);            // cooled: restart wait
    send_tick(12'sd0, 1'b1, 32'd10, 32'd750);             // waits for switch-off
    send_tick(12'sd0, 1'b0, 32'd11, 32'd1000);            // back to adjusting
    send_tick(12'sd600, 1'b1, 32'd12, 32'd1250);          // too hot to start
    send_tick(12'sh800, 1'b1, 32'd123, 32'd1000);         // coldest sample starts
    send_tick(12'sh7FF, 1'b0, 32'd124, 32'd1250);         // switch-off beats overheat
  endtask

  // Mostly well-formed streams: temps mostly near a live threshold or curve edge,
  // switch mostly on, stamps moving forward; the rest is raw noise.
  task automatic test_random_phase(input int src_pct, input int snk_pct,
                                   input logic signed [TEMP_W-1:0] w,
                                   input logic signed [TEMP_W-1:0] o,
                                   input logic signed [TEMP_W-1:0] r, input int n);
    int                       base;
    logic signed [TEMP_W-1:0] t;
    logic                     run;
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    write_thresholds(w, o, r);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 80) begin
        case ($urandom_range(4))
          0:       base = int'(warn_lvl);
          1:       base = int'(trip_lvl);
          2:       base = int'(restart_lvl);
          3:       base = CURVE_BASE + CURVE_STEP * int'($urandom_range(CURVE_EDGES - 1));
          default: base = int'($urandom_range(1900)) - 400;
        endcase
        t   = TEMP_W'(base + int'($urandom_range(120)) - 60);
        run = ($urandom_range(9) != 0);
        // Now and then a huge jump so long stopwatch values show up.
        if ($urandom_range(99) < 3) us_clock += $urandom;
        else us_clock += TS_W'($urandom_range(2500000));
        ms_clock += TS_W'($urandom_range(700));
        send_tick(t, run, us_clock, ms_clock);
      end else begin
        send_tick(TEMP_W'($urandom), 1'($urandom), $urandom, $urandom);
      end
    end
    end_phase();
  endtask

  // Receiver goes quiet while ticks keep coming, so the pipe fills and
  // in_ready_o must drop; then the sender waits for the pipe to empty.
  task automatic test_backpressure();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    write_thresholds(12'sd300, 12'sd800, 12'sd100);
    @(posedge clk_i);
    hold_req = 1'b1;
    for (int i = 0; i < 60; i++) begin
      us_clock += TS_W'($urandom_range(2000000));
      ms_clock += TS_W'($urandom_range(700));
      send_tick(TEMP_W'($urandom_range(1100)), ($urandom_range(9) != 0), us_clock, ms_clock);
    end
    end_phase();
  endtask

  function automatic void compare_field(input string name, input logic [31:0] want_v,
                                        input logic [31:0] got_v);
    if (want_v != got_v) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
    end
  endfunction

  // Receiver side: random stalls, or a counted hold-off when asked.
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Every result beat is matched against the oldest prediction.
  always @(posedge clk_i) begin
    status_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_status.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) $display("%0t: result beat with nothing expected", $time);
      end else begin
        want = pending_status.pop_front();
        compare_field("mode", 32'(want.mode), 32'(mode_o));
        compare_field("fan_duty", 32'(want.duty), 32'(fan_duty_o));
        compare_field("relay_on", 32'(want.relay), 32'(relay_on_o));
        compare_field("alarm_on", 32'(want.alarm), 32'(alarm_on_o));
        compare_field("alarm_led", 32'(want.led), 32'(alarm_led_o));
        compare_field("elapsed_seconds", 32'(want.secs), 32'(elapsed_seconds_o));
      end
    end
  end

  initial begin
    int w_r;
    int o_r;
    int r_r;
    us_clock = $urandom;
    ms_clock = $urandom;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed ticks run on the reset thresholds, no idling.
    test_fan_curve();
    test_field_extremes();
    test_mode_walk();
    end_phase();

    // Random phases, each with its own thresholds and traffic shape.
    test_random_phase(0, 0, ogfc_pkg::WARNING_RST, ogfc_pkg::OVERHEAT_RST,
                      ogfc_pkg::RESTART_RST, 250);
    test_random_phase(67, 0, 12'sh7FF, 12'sh7FF, 12'sh800, 150);
    test_random_phase(0, 67, 12'sh800, 12'sh800, 12'sh7FF, 150);
    w_r = int'($urandom_range(1900)) - 400;
    o_r = int'($urandom_range(1900)) - 400;
    r_r = int'($urandom_range(1900)) - 400;
    test_random_phase(33, 33, TEMP_W'(w_r), TEMP_W'(o_r), TEMP_W'(r_r), 300);
    test_backpressure();
    test_random_phase(33, 33, 12'sd250, 12'sd700, 12'sd650, 250);
    // Restart level above the trip level: overheat lets go on any sample at or below the restart level.
    test_random_phase(0, 0, 12'sd550, 12'sd500, 12'sd520, 150);

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending_status.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
